// ===== rtl/core/bft_pkg.sv =====
package bft_pkg;

    localparam int CNT_W  = 40;
    localparam int BYTE_W = 48;
    localparam int LEN_W  = 16;
    localparam int SLOT_OUT_W = 10;

    localparam logic [7:0] PROTO_TCP = 8'd6;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

    // tcp mark bit positions
    localparam int MARK_SYN  = 0;
    localparam int MARK_FIN  = 1;
    localparam int MARK_RST  = 2;
    localparam int MARK_DONE = 3;

    // application classes
    localparam logic [3:0] APP_NONE  = 4'd0;
    localparam logic [3:0] APP_HTTP  = 4'd1;
    localparam logic [3:0] APP_HTTPS = 4'd2;
    localparam logic [3:0] APP_DNS   = 4'd3;
    localparam logic [3:0] APP_FTP   = 4'd4;
    localparam logic [3:0] APP_SSH   = 4'd5;
    localparam logic [3:0] APP_SMTP  = 4'd6;
    localparam logic [3:0] APP_POP3  = 4'd7;
    localparam logic [3:0] APP_IMAP  = 4'd8;

    typedef struct packed {
        logic [7:0]  proto;
        logic [31:0] addr_a;
        logic [15:0] port_a;
        logic [31:0] addr_b;
        logic [15:0] port_b;
    } t_key;

    typedef struct packed {
        logic clr_wr;
        logic start;
        logic rd;
        logic commit;
        logic evict;
    } t_cmd;

    typedef struct packed {
        logic evict_pending;
    } t_stat;

    function automatic logic [3:0] app_of(input logic [15:0] pa, input logic [15:0] pb);
        logic [15:0] p;
        logic [3:0]  c;
        p = (pa < pb) ? pa : pb;
        case (p)
            16'd80, 16'd8080:  c = APP_HTTP;
            16'd443, 16'd8443: c = APP_HTTPS;
            16'd53:            c = APP_DNS;
            16'd21:            c = APP_FTP;
            16'd22:            c = APP_SSH;
            16'd25, 16'd587:   c = APP_SMTP;
            16'd110, 16'd995:  c = APP_POP3;
            16'd143, 16'd993:  c = APP_IMAP;
            default:           c = APP_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
        return (a == CNT_MAX) ? a : a + 1'b1;
    endfunction

    function automatic logic [BYTE_W-1:0] sat_add_len(input logic [BYTE_W-1:0] a,
                                                      input logic [LEN_W-1:0] b);
        logic [BYTE_W:0] s;
        s = {1'b0, a} + {{(BYTE_W+1-LEN_W){1'b0}}, b};
        return s[BYTE_W] ? BYTE_MAX : s[BYTE_W-1:0];
    endfunction

endpackage

// ===== rtl/core/bft_ctrl.sv =====
module bft_ctrl #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bft_pkg::t_stat                 i_stat,
    output bft_pkg::t_cmd                  o_cmd,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_addr
);
    localparam int SW = $clog2(TABLE_SLOTS);
    localparam logic [SW-1:0] LAST = SW'(TABLE_SLOTS - 1);

    localparam logic [2:0] ST_CLR    = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_TAIL   = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;
    localparam logic [2:0] ST_EVICT  = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [SW-1:0] r_cnt, n_cnt;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // sequencing of clear pass, scan, commit and late eviction
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_addr  = r_cnt;
        unique case (r_state)
            ST_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd.start = 1'b1;
                    n_cnt   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd = 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = ST_TAIL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_TAIL: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = i_stat.evict_pending ? ST_EVICT : ST_IDLE;
            end
            ST_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/core/bft_datapath.sv =====
module bft_datapath #(
    parameter int TABLE_SLOTS = 1024,
    parameter int TIME_BITS   = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bft_pkg::t_cmd                  i_cmd,
    input  logic [$clog2(TABLE_SLOTS)-1:0] i_addr,
    output bft_pkg::t_stat                 o_stat,
    input  logic                           i_cfg_we,
    input  logic [9:0]                     i_cfg_wdata,
    input  logic [7:0]                     i_ip_protocol,
    input  logic [31:0]                    i_source_address,
    input  logic [15:0]                    i_source_port,
    input  logic [31:0]                    i_dest_address,
    input  logic [15:0]                    i_dest_port,
    input  logic [15:0]                    i_frame_length,
    input  logic [47:0]                    i_arrival_ms,
    input  logic [39:0]                    i_sequence_number,
    input  logic                           i_flag_syn,
    input  logic                           i_flag_fin,
    input  logic                           i_flag_rst,
    output logic                           o_result_valid,
    output logic [9:0]                     o_flow_slot,
    output logic                           o_created,
    output logic                           o_forward_dir,
    output logic [3:0]                     o_app_class,
    output logic                           o_tcp_done,
    output logic [47:0]                    o_span_ms,
    output logic                           o_evicted,
    output logic [9:0]                     o_evicted_slot,
    output logic [39:0]                    o_grand_packets,
    output logic [47:0]                    o_grand_bytes
);
    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int TW = (TIME_BITS < 48) ? TIME_BITS : 48;
    localparam int LW = $clog2(TABLE_SLOTS + 1);
    localparam int CW = LW + 11;
    localparam int CNT_W  = bft_pkg::CNT_W;
    localparam int BYTE_W = bft_pkg::BYTE_W;

    // entry memories
    logic              m_valid [TABLE_SLOTS];
    bft_pkg::t_key     m_key   [TABLE_SLOTS];
    logic [TW-1:0]     m_first [TABLE_SLOTS];
    logic [TW-1:0]     m_last  [TABLE_SLOTS];
    logic [CNT_W-1:0]  m_cf    [TABLE_SLOTS];
    logic [BYTE_W-1:0] m_bf    [TABLE_SLOTS];
    logic [CNT_W-1:0]  m_cr    [TABLE_SLOTS];
    logic [BYTE_W-1:0] m_br    [TABLE_SLOTS];
    logic [3:0]        m_marks [TABLE_SLOTS];
    logic [39:0]       m_syn   [TABLE_SLOTS];
    logic [39:0]       m_fin   [TABLE_SLOTS];

    // registered read data
    logic              r_rv;
    bft_pkg::t_key     r_rkey;
    logic [TW-1:0]     r_rfirst, r_rlast;
    logic [CNT_W-1:0]  r_rcf, r_rcr;
    logic [BYTE_W-1:0] r_rbf, r_rbr;
    logic [3:0]        r_rmarks;
    logic [39:0]       r_rsyn, r_rfin;
    logic              r_pv;
    logic [SW-1:0]     r_pa;

    // request latch
    bft_pkg::t_key r_pkey;
    logic [15:0]   r_len;
    logic [TW-1:0] r_t;
    logic [39:0]   r_ord;
    logic          r_syn, r_fin, r_rst;

    // scan results
    logic              r_hit, r_free_found, r_old_found;
    logic [SW-1:0]     r_hslot, r_free, r_old_slot;
    logic [TW-1:0]     r_old_last;
    bft_pkg::t_key     r_hkey;
    logic [TW-1:0]     r_hfirst;
    logic [CNT_W-1:0]  r_hcf, r_hcr;
    logic [BYTE_W-1:0] r_hbf, r_hbr;
    logic [3:0]        r_hmarks;
    logic [39:0]       r_hsyn, r_hfin;

    logic [9:0]        r_max_flows;
    logic [LW-1:0]     r_live;
    logic [CNT_W-1:0]  r_ptotal;
    logic [BYTE_W-1:0] r_btotal;
    logic [SW-1:0]     r_ev_slot;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_flows <= 10'd1023;
        end else if (i_cfg_we) begin
            r_max_flows <= i_cfg_wdata;
        end
    end

    // latch request at start
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pkey <= '{proto: i_ip_protocol, addr_a: i_source_address,
                        port_a: i_source_port, addr_b: i_dest_address,
                        port_b: i_dest_port};
            r_len  <= i_frame_length;
            r_t    <= TW'(i_arrival_ms);
            r_ord  <= i_sequence_number;
            r_syn  <= i_flag_syn;
            r_fin  <= i_flag_fin;
            r_rst  <= i_flag_rst;
        end
    end

    // scan read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rv     <= m_valid[i_addr];
            r_rkey   <= m_key[i_addr];
            r_rfirst <= m_first[i_addr];
            r_rlast  <= m_last[i_addr];
            r_rcf    <= m_cf[i_addr];
            r_rbf    <= m_bf[i_addr];
            r_rcr    <= m_cr[i_addr];
            r_rbr    <= m_br[i_addr];
            r_rmarks <= m_marks[i_addr];
            r_rsyn   <= m_syn[i_addr];
            r_rfin   <= m_fin[i_addr];
        end
        r_pa <= i_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.rd;
        end
    end

    // direction-blind key compare on the slot just read
    logic s_match, s_older;
    always_comb begin
        s_match = r_rv && (r_rkey.proto == r_pkey.proto) &&
            ((r_rkey.addr_a == r_pkey.addr_a && r_rkey.port_a == r_pkey.port_a &&
              r_rkey.addr_b == r_pkey.addr_b && r_rkey.port_b == r_pkey.port_b) ||
             (r_rkey.addr_a == r_pkey.addr_b && r_rkey.port_a == r_pkey.port_b &&
              r_rkey.addr_b == r_pkey.addr_a && r_rkey.port_b == r_pkey.port_a));
        s_older = r_rv && (!r_old_found || (r_rlast < r_old_last));
    end

    // scan tracking: first hit, first free, oldest valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_old_found  <= 1'b0;
        end else if (r_pv) begin
            if (s_match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (!r_rv && !r_free_found) begin
                r_free_found <= 1'b1;
            end
            if (s_older) begin
                r_old_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            if (s_match && !r_hit) begin
                r_hslot  <= r_pa;
                r_hkey   <= r_rkey;
                r_hfirst <= r_rfirst;
                r_hcf    <= r_rcf;
                r_hbf    <= r_rbf;
                r_hcr    <= r_rcr;
                r_hbr    <= r_rbr;
                r_hmarks <= r_rmarks;
                r_hsyn   <= r_rsyn;
                r_hfin   <= r_rfin;
            end
            if (!r_rv && !r_free_found) begin
                r_free <= r_pa;
            end
            if (s_older) begin
                r_old_slot <= r_pa;
                r_old_last <= r_rlast;
            end
        end
    end

    // commit computation
    logic              c_full_ev, c_fwd, c_post_ev, c_new_valid;
    logic [SW-1:0]     c_slot, c_ev_slot;
    bft_pkg::t_key     c_key;
    logic [TW-1:0]     c_first, c_span;
    logic [CNT_W-1:0]  c_cf, c_cr;
    logic [BYTE_W-1:0] c_bf, c_br;
    logic [3:0]        c_marks;
    logic [39:0]       c_syn, c_fin;
    logic [CW-1:0]     c_live_inc;

    always_comb begin
        c_full_ev = !r_hit && !r_free_found;
        c_slot    = r_hit ? r_hslot : (r_free_found ? r_free : r_old_slot);
        c_fwd     = !r_hit || (r_hkey.addr_a == r_pkey.addr_a &&
                               r_hkey.port_a == r_pkey.port_a);
        if (r_hit) begin
            c_key   = r_hkey;
            c_first = r_hfirst;
            c_cf    = r_hcf;
            c_bf    = r_hbf;
            c_cr    = r_hcr;
            c_br    = r_hbr;
            c_marks = r_hmarks;
            c_syn   = r_hsyn;
            c_fin   = r_hfin;
            if (c_fwd) begin
                c_cf = bft_pkg::sat_inc(r_hcf);
                c_bf = bft_pkg::sat_add_len(r_hbf, r_len);
            end else begin
                c_cr = bft_pkg::sat_inc(r_hcr);
                c_br = bft_pkg::sat_add_len(r_hbr, r_len);
            end
        end else begin
            c_key   = r_pkey;
            c_first = r_t;
            c_cf    = CNT_W'(1);
            c_bf    = BYTE_W'(r_len);
            c_cr    = '0;
            c_br    = '0;
            c_marks = '0;
            c_syn   = '0;
            c_fin   = '0;
        end
        // tcp flag recording
        if (r_pkey.proto == bft_pkg::PROTO_TCP) begin
            if (r_syn) begin
                if (!c_marks[bft_pkg::MARK_SYN]) begin
                    c_syn = r_ord;
                end
                c_marks[bft_pkg::MARK_SYN] = 1'b1;
            end
            if (r_fin) begin
                c_marks[bft_pkg::MARK_FIN] = 1'b1;
                c_fin = r_ord;
            end
            if (r_rst) begin
                c_marks[bft_pkg::MARK_RST] = 1'b1;
            end
            if (c_marks[bft_pkg::MARK_SYN] &&
                (c_marks[bft_pkg::MARK_FIN] || c_marks[bft_pkg::MARK_RST])) begin
                c_marks[bft_pkg::MARK_DONE] = 1'b1;
            end
        end
        c_span = (r_t >= c_first) ? (r_t - c_first) : '0;
        // limit check once the new flow is in
        c_live_inc = CW'(r_live) + CW'(1);
        c_post_ev  = !r_hit && !c_full_ev && (c_live_inc > CW'(r_max_flows));
        if (!r_old_found || (r_t < r_old_last) ||
            (r_t == r_old_last && c_slot < r_old_slot)) begin
            c_ev_slot = c_slot;
        end else begin
            c_ev_slot = r_old_slot;
        end
        if (c_full_ev) begin
            c_ev_slot = r_old_slot;
        end
        c_new_valid = !(c_post_ev && c_ev_slot == c_slot);
        o_stat.evict_pending = c_post_ev && (c_ev_slot != c_slot);
    end

    // valid memory: clearing pass, commit, late eviction
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            m_valid[i_addr] <= 1'b0;
        end else if (i_cmd.commit) begin
            m_valid[c_slot] <= c_new_valid;
        end else if (i_cmd.evict) begin
            m_valid[r_ev_slot] <= 1'b0;
        end
    end

    // entry write-back
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            m_key[c_slot]   <= c_key;
            m_first[c_slot] <= c_first;
            m_last[c_slot]  <= r_t;
            m_cf[c_slot]    <= c_cf;
            m_bf[c_slot]    <= c_bf;
            m_cr[c_slot]    <= c_cr;
            m_br[c_slot]    <= c_br;
            m_marks[c_slot] <= c_marks;
            m_syn[c_slot]   <= c_syn;
            m_fin[c_slot]   <= c_fin;
            r_ev_slot       <= c_ev_slot;
        end
    end

    // live count and running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live   <= '0;
            r_ptotal <= '0;
            r_btotal <= '0;
        end else if (i_cmd.commit) begin
            if (!r_hit && !c_full_ev) begin
                r_live <= c_post_ev ? r_live : LW'(c_live_inc);
            end
            r_ptotal <= bft_pkg::sat_inc(r_ptotal);
            r_btotal <= bft_pkg::sat_add_len(r_btotal, r_len);
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.commit;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_flow_slot     <= 10'(c_slot);
            o_created       <= !r_hit;
            o_forward_dir   <= c_fwd;
            o_app_class     <= bft_pkg::app_of(c_key.port_a, c_key.port_b);
            o_tcp_done      <= c_marks[bft_pkg::MARK_DONE];
            o_span_ms       <= 48'(c_span);
            o_evicted       <= c_full_ev || c_post_ev;
            o_evicted_slot  <= (c_full_ev || c_post_ev) ? 10'(c_ev_slot) : 10'd0;
            o_grand_packets <= bft_pkg::sat_inc(r_ptotal);
            o_grand_bytes   <= bft_pkg::sat_add_len(r_btotal, r_len);
        end
    end

endmodule

// ===== rtl/core/bidirectional_flow_table.sv =====
// a request scans every slot, then passes the tail and commit states; the result is registered
// a new request is not taken until the last one is through, busy stays high until then; a late
//   eviction needs its own write after the commit; the scan of the entry memory reads one slot a cycle
// reset: after release a clearing pass over every slot holds busy high
// results are strobed for one cycle; the receiver cannot stall
module bidirectional_flow_table #(
    parameter int TABLE_SLOTS = 1024,
    parameter int TIME_BITS   = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    input  logic [7:0]  i_ip_protocol,
    input  logic [31:0] i_source_address,
    input  logic [15:0] i_source_port,
    input  logic [31:0] i_dest_address,
    input  logic [15:0] i_dest_port,
    input  logic [15:0] i_frame_length,
    input  logic [47:0] i_arrival_ms,
    input  logic [39:0] i_sequence_number,
    input  logic        i_flag_syn,
    input  logic        i_flag_fin,
    input  logic        i_flag_rst,
    output logic        o_result_valid,
    output logic [9:0]  o_flow_slot,
    output logic        o_created,
    output logic        o_forward_dir,
    output logic [3:0]  o_app_class,
    output logic        o_tcp_done,
    output logic [47:0] o_span_ms,
    output logic        o_evicted,
    output logic [9:0]  o_evicted_slot,
    output logic [39:0] o_grand_packets,
    output logic [47:0] o_grand_bytes
);
    bft_pkg::t_cmd                  w_cmd;
    bft_pkg::t_stat                 w_stat;
    logic [$clog2(TABLE_SLOTS)-1:0] w_addr;

    // controller
    bft_ctrl #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_stat (w_stat),
        .o_cmd  (w_cmd),
        .o_addr (w_addr)
    );

    // datapath
    bft_datapath #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_addr           (w_addr),
        .o_stat           (w_stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_ip_protocol    (i_ip_protocol),
        .i_source_address (i_source_address),
        .i_source_port    (i_source_port),
        .i_dest_address   (i_dest_address),
        .i_dest_port      (i_dest_port),
        .i_frame_length   (i_frame_length),
        .i_arrival_ms     (i_arrival_ms),
        .i_sequence_number(i_sequence_number),
        .i_flag_syn       (i_flag_syn),
        .i_flag_fin       (i_flag_fin),
        .i_flag_rst       (i_flag_rst),
        .o_result_valid   (o_result_valid),
        .o_flow_slot      (o_flow_slot),
        .o_created        (o_created),
        .o_forward_dir    (o_forward_dir),
        .o_app_class      (o_app_class),
        .o_tcp_done       (o_tcp_done),
        .o_span_ms        (o_span_ms),
        .o_evicted        (o_evicted),
        .o_evicted_slot   (o_evicted_slot),
        .o_grand_packets  (o_grand_packets),
        .o_grand_bytes    (o_grand_bytes)
    );

    // an accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request");

    // results never come back to back
    a_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("two results in consecutive cycles");

    // a new flow always has its sender as endpoint a
    a_created_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_created) |-> o_forward_dir)
        else $error("new flow not in forward direction");

    // evicted slot is zero when nothing was evicted
    a_ev_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_evicted) |-> (o_evicted_slot == 10'd0))
        else $error("evicted slot set without eviction");

endmodule

// ===== tb/bidirectional_flow_table_checker.sv =====
`timescale 1ns / 1ps

module bidirectional_flow_table_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    input  logic [7:0]  i_ip_protocol,
    input  logic [31:0] i_source_address,
    input  logic [15:0] i_source_port,
    input  logic [31:0] i_dest_address,
    input  logic [15:0] i_dest_port,
    input  logic [15:0] i_frame_length,
    input  logic [47:0] i_arrival_ms,
    input  logic [39:0] i_sequence_number,
    input  logic        i_flag_syn,
    input  logic        i_flag_fin,
    input  logic        i_flag_rst,
    input  logic        i_result_valid,
    input  logic [9:0]  i_flow_slot,
    input  logic        i_created,
    input  logic        i_forward_dir,
    input  logic [3:0]  i_app_class,
    input  logic        i_tcp_done,
    input  logic [47:0] i_span_ms,
    input  logic        i_evicted,
    input  logic [9:0]  i_evicted_slot,
    input  logic [39:0] i_grand_packets,
    input  logic [47:0] i_grand_bytes,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_creates,
    output int          o_evictions
);

    localparam int SLOTS = 1024;

    typedef struct packed {
        logic [9:0]  flow_slot;
        logic        created;
        logic        forward_dir;
        logic [3:0]  app_class;
        logic        tcp_done;
        logic [47:0] span_ms;
        logic        evicted;
        logic [9:0]  evicted_slot;
        logic [39:0] grand_packets;
        logic [47:0] grand_bytes;
    } t_flow_result;

    // shadow copy of the flow table
    logic          live_slot [SLOTS];
    bft_pkg::t_key key_of    [SLOTS];
    logic [47:0]   opened_at [SLOTS];
    logic [47:0]   seen_at   [SLOTS];
    logic [3:0]    marks_of  [SLOTS];
    int            live_flows;
    logic [9:0]    flow_limit;
    logic [39:0]   packets_seen;
    logic [47:0]   bytes_seen;

    t_flow_result awaited_results[$];

    function automatic logic [3:0] service_class(input logic [15:0] pa, input logic [15:0] pb);
        logic [15:0] lo;
        lo = (pa < pb) ? pa : pb;
        case (lo)
            16'd80, 16'd8080:  return bft_pkg::APP_HTTP;
            16'd443, 16'd8443: return bft_pkg::APP_HTTPS;
            16'd53:            return bft_pkg::APP_DNS;
            16'd21:            return bft_pkg::APP_FTP;
            16'd22:            return bft_pkg::APP_SSH;
            16'd25, 16'd587:   return bft_pkg::APP_SMTP;
            16'd110, 16'd995:  return bft_pkg::APP_POP3;
            16'd143, 16'd993:  return bft_pkg::APP_IMAP;
            default:           return bft_pkg::APP_NONE;
        endcase
    endfunction

    // lowest valid slot with the oldest last-seen time
    function automatic int stalest_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (live_slot[i] && (best < 0 || seen_at[i] < seen_at[best])) begin
                best = i;
            end
        end
        return (best < 0) ? 0 : best;
    endfunction

    task automatic track_packet(output t_flow_result r);
        int   slot;
        int   gone;
        logic hit;
        logic fwd;
        logic gone_flag;
        logic [3:0] m;
        slot = 0;
        gone = 0;
        hit = 1'b0;
        fwd = 1'b1;
        gone_flag = 1'b0;
        // direction-blind lookup
        for (int i = 0; i < SLOTS && !hit; i++) begin
            if (live_slot[i] && key_of[i].proto == i_ip_protocol) begin
                if ((key_of[i].addr_a == i_source_address && key_of[i].port_a == i_source_port &&
                     key_of[i].addr_b == i_dest_address && key_of[i].port_b == i_dest_port) ||
                    (key_of[i].addr_a == i_dest_address && key_of[i].port_a == i_dest_port &&
                     key_of[i].addr_b == i_source_address && key_of[i].port_b == i_source_port)) begin
                    hit = 1'b1;
                    slot = i;
                end
            end
        end
        if (hit) begin
            fwd = (key_of[slot].addr_a == i_source_address && key_of[slot].port_a == i_source_port);
            seen_at[slot] = i_arrival_ms;
        end else begin
            slot = -1;
            for (int i = 0; i < SLOTS && slot < 0; i++) begin
                if (!live_slot[i]) slot = i;
            end
            // table full: reuse the stalest slot
            if (slot < 0) begin
                slot = stalest_slot();
                gone_flag = 1'b1;
                gone = slot;
                if (live_flows > 0) live_flows--;
            end
            live_slot[slot] = 1'b1;
            key_of[slot] = '{i_ip_protocol, i_source_address, i_source_port,
                             i_dest_address, i_dest_port};
            opened_at[slot] = i_arrival_ms;
            seen_at[slot] = i_arrival_ms;
            marks_of[slot] = '0;
            live_flows++;
        end
        if (i_ip_protocol == bft_pkg::PROTO_TCP) begin
            m = marks_of[slot];
            if (i_flag_syn) m[bft_pkg::MARK_SYN] = 1'b1;
            if (i_flag_fin) m[bft_pkg::MARK_FIN] = 1'b1;
            if (i_flag_rst) m[bft_pkg::MARK_RST] = 1'b1;
            if (m[bft_pkg::MARK_SYN] && (m[bft_pkg::MARK_FIN] || m[bft_pkg::MARK_RST])) begin
                m[bft_pkg::MARK_DONE] = 1'b1;
            end
            marks_of[slot] = m;
        end
        r.flow_slot = slot[9:0];
        r.created = !hit;
        r.forward_dir = fwd;
        r.app_class = service_class(key_of[slot].port_a, key_of[slot].port_b);
        r.tcp_done = marks_of[slot][bft_pkg::MARK_DONE];
        r.span_ms = (seen_at[slot] >= opened_at[slot]) ? seen_at[slot] - opened_at[slot] : '0;
        // one late eviction when the limit is exceeded
        if (!hit && !gone_flag && live_flows > flow_limit) begin
            gone = stalest_slot();
            live_slot[gone] = 1'b0;
            live_flows--;
            gone_flag = 1'b1;
        end
        if (packets_seen != bft_pkg::CNT_MAX) packets_seen++;
        bytes_seen = ({1'b0, bytes_seen} + i_frame_length > bft_pkg::BYTE_MAX) ?
                     bft_pkg::BYTE_MAX : bytes_seen + i_frame_length;
        r.evicted = gone_flag;
        r.evicted_slot = gone_flag ? gone[9:0] : '0;
        r.grand_packets = packets_seen;
        r.grand_bytes = bytes_seen;
        if (!hit) o_creates++;
        if (gone_flag) o_evictions++;
    endtask

    function automatic void compare_field(input string name, input logic [47:0] want,
                                          input logic [47:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_creates = 0;
        o_evictions = 0;
        for (int i = 0; i < SLOTS; i++) live_slot[i] = 1'b0;
        live_flows = 0;
        flow_limit = 10'd1023;
        packets_seen = '0;
        bytes_seen = '0;
    end

    assign o_pending = awaited_results.size();

    // watch config, requests and results at each edge
    always @(posedge i_clk) begin
        t_flow_result want;
        if (i_rst_n) begin
            if (i_cfg_we) flow_limit = i_cfg_wdata;
            if (i_start && !i_busy) begin
                track_packet(want);
                awaited_results.push_back(want);
            end
            if (i_result_valid) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no request outstanding, slot %0d", i_flow_slot);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("flow_slot", want.flow_slot, i_flow_slot);
                    compare_field("created", want.created, i_created);
                    compare_field("forward_dir", want.forward_dir, i_forward_dir);
                    compare_field("app_class", want.app_class, i_app_class);
                    compare_field("tcp_done", want.tcp_done, i_tcp_done);
                    compare_field("span_ms", want.span_ms, i_span_ms);
                    compare_field("evicted", want.evicted, i_evicted);
                    compare_field("evicted_slot", want.evicted_slot, i_evicted_slot);
                    compare_field("grand_packets", want.grand_packets, i_grand_packets);
                    compare_field("grand_bytes", want.grand_bytes, i_grand_bytes);
                end
            end
        end
    end

endmodule

// ===== tb/bidirectional_flow_table_test.sv =====
`timescale 1ns / 1ps

module bidirectional_flow_table_test;

    localparam logic [7:0] PROTO_TCP = bft_pkg::PROTO_TCP;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [9:0]  i_cfg_wdata;
    logic [7:0]  i_ip_protocol;
    logic [31:0] i_source_address;
    logic [15:0] i_source_port;
    logic [31:0] i_dest_address;
    logic [15:0] i_dest_port;
    logic [15:0] i_frame_length;
    logic [47:0] i_arrival_ms;
    logic [39:0] i_sequence_number;
    logic        i_flag_syn;
    logic        i_flag_fin;
    logic        i_flag_rst;
    logic        o_result_valid;
    logic [9:0]  o_flow_slot;
    logic        o_created;
    logic        o_forward_dir;
    logic [3:0]  o_app_class;
    logic        o_tcp_done;
    logic [47:0] o_span_ms;
    logic        o_evicted;
    logic [9:0]  o_evicted_slot;
    logic [39:0] o_grand_packets;
    logic [47:0] o_grand_bytes;

    int fail_count;
    int pending;
    int creates;
    int evictions;

    // endpoint pool so that flows recur in both directions
    logic [31:0] host_addr [8];
    logic [15:0] host_port [8];
    logic [47:0] clock_ms;
    logic [39:0] ordinal;
    bit          allow_gaps;
    int          sent;

    bidirectional_flow_table i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_ip_protocol(i_ip_protocol), .i_source_address(i_source_address),
        .i_source_port(i_source_port), .i_dest_address(i_dest_address),
        .i_dest_port(i_dest_port), .i_frame_length(i_frame_length),
        .i_arrival_ms(i_arrival_ms), .i_sequence_number(i_sequence_number),
        .i_flag_syn(i_flag_syn), .i_flag_fin(i_flag_fin), .i_flag_rst(i_flag_rst),
        .o_result_valid(o_result_valid), .o_flow_slot(o_flow_slot),
        .o_created(o_created), .o_forward_dir(o_forward_dir),
        .o_app_class(o_app_class), .o_tcp_done(o_tcp_done), .o_span_ms(o_span_ms),
        .o_evicted(o_evicted), .o_evicted_slot(o_evicted_slot),
        .o_grand_packets(o_grand_packets), .o_grand_bytes(o_grand_bytes)
    );

    bidirectional_flow_table_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_ip_protocol(i_ip_protocol), .i_source_address(i_source_address),
        .i_source_port(i_source_port), .i_dest_address(i_dest_address),
        .i_dest_port(i_dest_port), .i_frame_length(i_frame_length),
        .i_arrival_ms(i_arrival_ms), .i_sequence_number(i_sequence_number),
        .i_flag_syn(i_flag_syn), .i_flag_fin(i_flag_fin), .i_flag_rst(i_flag_rst),
        .i_result_valid(o_result_valid), .i_flow_slot(o_flow_slot),
        .i_created(o_created), .i_forward_dir(o_forward_dir),
        .i_app_class(o_app_class), .i_tcp_done(o_tcp_done), .i_span_ms(o_span_ms),
        .i_evicted(o_evicted), .i_evicted_slot(o_evicted_slot),
        .i_grand_packets(o_grand_packets), .i_grand_bytes(o_grand_bytes),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_creates(creates), .o_evictions(evictions)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // hand one request to the block and hold it until taken
    task automatic send_packet(input logic [7:0] proto, input logic [31:0] sa,
                               input logic [15:0] sp, input logic [31:0] da,
                               input logic [15:0] dp, input logic [15:0] len,
                               input logic [47:0] t, input logic [39:0] seq,
                               input logic [2:0] flags);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_ip_protocol <= proto;
        i_source_address <= sa;
        i_source_port <= sp;
        i_dest_address <= da;
        i_dest_port <= dp;
        i_frame_length <= len;
        i_arrival_ms <= t;
        i_sequence_number <= seq;
        {i_flag_syn, i_flag_fin, i_flag_rst} <= flags;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    // wait for the table to drain, then set a new flow limit
    task automatic set_flow_limit(input logic [9:0] limit);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_packets(input int count);
        int a;
        int b;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 24) == 0) begin
                // noise: every field at random
                send_packet(8'($urandom), $urandom, 16'($urandom), $urandom, 16'($urandom),
                            16'($urandom), 48'({$urandom, $urandom}),
                            40'({$urandom, $urandom}), 3'($urandom));
            end else begin
                a = $urandom_range(0, 7);
                b = $urandom_range(0, 7);
                if ($urandom_range(0, 15) == 0 && clock_ms > 200) clock_ms -= $urandom_range(1, 200);
                else clock_ms += $urandom_range(0, 60);
                ordinal++;
                send_packet(($urandom_range(0, 2) == 0) ? 8'd17 : PROTO_TCP,
                            host_addr[a], host_port[a], host_addr[b], host_port[b],
                            16'($urandom), clock_ms, ordinal,
                            ($urandom_range(0, 2) == 0) ? 3'($urandom) : 3'b000);
            end
        end
    endtask

    initial begin
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_ip_protocol = '0;
        i_source_address = '0;
        i_source_port = '0;
        i_dest_address = '0;
        i_dest_port = '0;
        i_frame_length = '0;
        i_arrival_ms = '0;
        i_sequence_number = '0;
        {i_flag_syn, i_flag_fin, i_flag_rst} = '0;
        i_rst_n = 1'b0;
        allow_gaps = 1'b1;
        sent = 0;
        clock_ms = 48'd1000;
        ordinal = 40'd1;
        host_port = '{16'd80, 16'd443, 16'd53, 16'd22, 16'd40000, 16'd51515, 16'd993, 16'd8080};
        for (int i = 0; i < 8; i++) host_addr[i] = $urandom;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        set_flow_limit(10'd1023);

        // directed: field extremes, services, directions, tcp marks, time backwards
        send_packet(8'd0, 32'h0, 16'h0, 32'h0, 16'h0, 16'h0, 48'h0, 40'h0, 3'b000);
        send_packet(8'd255, '1, '1, '1, '1, '1, '1, '1, 3'b111);
        send_packet(8'd17, 32'h0a000001, 16'd80, 32'h0a000002, 16'd5000, 16'd60, 48'd10, 40'd3, 3'b000);
        send_packet(8'd17, 32'h0a000002, 16'd5000, 32'h0a000001, 16'd80, 16'd1500, 48'd25, 40'd4, 3'b000);
        send_packet(8'd17, 32'h0a000001, 16'd8080, 32'h0a000002, 16'd9000, 16'd1, 48'd26, 40'd5, 3'b000);
        send_packet(8'd17, 32'h0a000001, 16'd443, 32'h0a000002, 16'd9000, 16'd1, 48'd27, 40'd6, 3'b000);
        send_packet(8'd17, 32'h0a000001, 16'd8443, 32'h0a000002, 16'd9000, 16'd1, 48'd27, 40'd7, 3'b000);
        send_packet(8'd17, 32'h0a000003, 16'd53, 32'h0a000002, 16'd9000, 16'd1, 48'd27, 40'd8, 3'b000);
        send_packet(PROTO_TCP, 32'h0a000003, 16'd21, 32'h0a000004, 16'd9000, 16'd1, 48'd28, 40'd9, 3'b000);
        send_packet(PROTO_TCP, 32'h0a000003, 16'd22, 32'h0a000004, 16'd9000, 16'd1, 48'd28, 40'd10, 3'b000);
        send_packet(PROTO_TCP, 32'h0a000003, 16'd25, 32'h0a000004, 16'd9000, 16'd1, 48'd29, 40'd11, 3'b000);
        send_packet(PROTO_TCP, 32'h0a000003, 16'd587, 32'h0a000004, 16'd9000, 16'd1, 48'd29, 40'd12, 3'b000);
        send_packet(PROTO_TCP, 32'h0a000003, 16'd110, 32'h0a000004, 16'd9000, 16'd1, 48'd30, 40'd13, 3'b000);
        send_packet(PROTO_TCP, 32'h0a000003, 16'd995, 32'h0a000004, 16'd9000, 16'd1, 48'd30, 40'd14, 3'b000);
        send_packet(PROTO_TCP, 32'h0a000003, 16'd143, 32'h0a000004, 16'd9000, 16'd1, 48'd31, 40'd15, 3'b000);
        send_packet(PROTO_TCP, 32'h0a000003, 16'd993, 32'h0a000004, 16'd9000, 16'd1, 48'd31, 40'd16, 3'b000);
        // syn on the opening packet, fin from the far side completes the flow
        send_packet(PROTO_TCP, 32'h0b000001, 16'd4000, 32'h0b000002, 16'd22, 16'd64, 48'd40, 40'd20, 3'b100);
        send_packet(PROTO_TCP, 32'h0b000002, 16'd22, 32'h0b000001, 16'd4000, 16'd64, 48'd45, 40'd21, 3'b100);
        send_packet(PROTO_TCP, 32'h0b000002, 16'd22, 32'h0b000001, 16'd4000, 16'd64, 48'd50, 40'd22, 3'b010);
        // rst alone does not complete, syn after rst does
        send_packet(PROTO_TCP, 32'h0c000001, 16'd4001, 32'h0c000002, 16'd80, 16'd40, 48'd60, 40'd30, 3'b001);
        send_packet(PROTO_TCP, 32'h0c000001, 16'd4001, 32'h0c000002, 16'd80, 16'd40, 48'd61, 40'd31, 3'b100);
        // time going backwards on an existing flow
        send_packet(PROTO_TCP, 32'h0c000002, 16'd80, 32'h0c000001, 16'd4001, 16'd40, 48'd5, 40'd32, 3'b000);
        // same endpoints, other protocol is a separate flow
        send_packet(8'd1, 32'h0c000001, 16'd4001, 32'h0c000002, 16'd80, 16'd40, 48'd62, 40'd33, 3'b000);

        // random phases across flow limits, extremes included
        random_packets(70);
        set_flow_limit(10'd3);
        random_packets(80);
        set_flow_limit(10'd1);
        random_packets(70);
        set_flow_limit(10'd0);
        random_packets(60);
        set_flow_limit(10'd12);
        random_packets(80);
        set_flow_limit(10'd2);
        random_packets(70);
        set_flow_limit(10'd1023);
        allow_gaps = 1'b0;
        random_packets(100);

        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
        $display("covered %0d packets over seven flow limits from 0 to 1023", sent);
        $display("flows opened %0d, flows evicted %0d", creates, evictions);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // run limit
    initial begin
        #40ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== bidirectional_flow_table.f =====
rtl/core/bft_pkg.sv
rtl/core/bft_ctrl.sv
rtl/core/bft_datapath.sv
rtl/core/bidirectional_flow_table.sv
tb/bidirectional_flow_table_checker.sv
tb/bidirectional_flow_table_test.sv
